// ----- design/bdr_pkg.sv -----
// shared constants and types for the barrel distortion remap block
package bdr_pkg;

    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC       = 12;
    localparam int Q24_SH     = 24;
    localparam int T_W        = 16;
    localparam int T2_W       = 2 * T_W - FRAC;
    localparam int T3_W       = T2_W + T_W - FRAC;
    localparam int M_W        = 41;
    localparam int RESET_DIM  = 4096;
    localparam int RESET_D    = 4096;

    localparam logic [T_W-1:0] T_MAX = '1;
    localparam logic [M_W-1:0] M_ONE = M_W'(1) << Q24_SH;
    localparam logic [M_W-1:0] M_CAP = {1'b1, {(M_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_D = 3'd3,
        CFG_IMG_W  = 3'd4,
        CFG_IMG_H  = 3'd5
    } cfg_reg_t;

endpackage

// ----- design/barrel_distortion_remap.sv -----
// barrel distortion remap: destination pixel to source pixel, fully pipelined
// result strobe (done) follows acceptance through the whole pipeline, whose length is
//   set by one stage per root bit (26) and per quotient bit (26 + 13)
// throughput: one transaction per clock, busy is always low, results cannot be stalled
// reset: rst_n clears valid bits and restores coefficients and image size to defaults
module barrel_distortion_remap #(
    parameter int MAX_DIM    = 4096,
    parameter int COEF_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bdr_pkg::COORD_W-1:0]        dst_x,
    input  logic [bdr_pkg::COORD_W-1:0]        dst_y,
    output logic                               done,
    output logic [bdr_pkg::COORD_W-1:0]        src_x,
    output logic [bdr_pkg::COORD_W-1:0]        src_y,
    output logic                               in_bounds,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // widths
    localparam int XW   = bdr_pkg::COORD_W;
    localparam int CW   = COEF_WIDTH;
    localparam int DW   = $clog2(MAX_DIM) + 1;         // image dimension register
    localparam int MW   = (XW + 1 > DW) ? XW + 1 : DW;
    localparam int OFW  = MW + 1;                      // doubled center offset, signed
    localparam int SW   = 2 * MW + 1;                  // squared radius sum
    localparam int NW   = SW + bdr_pkg::Q24_SH + (SW % 2);
    localparam int RTW  = NW / 2;                      // root width
    localparam int RMW  = RTW + 2;                     // root remainder
    localparam int TW   = bdr_pkg::T_W;
    localparam int T2W  = bdr_pkg::T2_W;
    localparam int T3W  = bdr_pkg::T3_W;
    localparam int PW   = CW + T3W + 3;                // polynomial sum
    localparam int MCW  = bdr_pkg::M_W;
    localparam int NUMW = DW + MCW + 2;                // source numerator
    localparam int QW   = DW;                          // source quotient

    // stage numbering
    localparam int ST_SQ  = 1;
    localparam int ST_SUM = 2;
    localparam int ST_RT0 = ST_SUM + 1;
    localparam int ST_D1  = ST_RT0 + RTW;
    localparam int ST_SAT = ST_D1 + RTW;
    localparam int ST_T2  = ST_SAT + 1;
    localparam int ST_T3  = ST_T2 + 1;
    localparam int ST_MUL = ST_T3 + 1;
    localparam int ST_P   = ST_MUL + 1;
    localparam int ST_M   = ST_P + 1;
    localparam int ST_NP  = ST_M + 1;
    localparam int ST_NUM = ST_NP + 1;
    localparam int ST_ABS = ST_NUM + 1;
    localparam int ST_OV  = ST_ABS + 1;
    localparam int ST_D2  = ST_OV + 1;
    localparam int NST    = ST_D2 + QW;
    localparam int LAT    = NST + 1;

    // one lane of the source divider
    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [QW-1:0]   q;
        logic            neg;
        logic            ov;
    } div_lane_t;

    // doubled offset from the image center: 2c - (dim - 1)
    function automatic logic signed [OFW-1:0] center_off(input logic [XW-1:0] c,
                                                          input logic [DW-1:0] dim);
        logic [OFW-1:0] r;
        r = OFW'({c, 1'b0}) - OFW'(dim) + OFW'(1);
        return $signed(r);
    endfunction

    // one restoring step of the source division
    function automatic div_lane_t div_step(input div_lane_t l, input logic [MCW-1:0] m,
                                           input int sh);
        logic [NUMW-1:0] dsh;
        div_lane_t       r;
        r   = l;
        dsh = NUMW'({m, 1'b0}) << sh;
        if (l.rem >= dsh)
        begin
            r.rem = l.rem - dsh;
            r.q   = {l.q[QW-2:0], 1'b1};
        end
        else
        begin
            r.q = {l.q[QW-2:0], 1'b0};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers, written only while the pipeline is empty
    // ------------------------------------------------------------------
    logic signed [CW-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [DW-1:0]        width_reg, height_reg;

    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= CW'(bdr_pkg::RESET_D);
            width_reg  <= DW'(bdr_pkg::RESET_DIM);
            height_reg <= DW'(bdr_pkg::RESET_DIM);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (bdr_pkg::cfg_reg_t'(cfg_index))
                bdr_pkg::CFG_COEF_A: coef_a_reg <= cfg_data[CW-1:0];
                bdr_pkg::CFG_COEF_B: coef_b_reg <= cfg_data[CW-1:0];
                bdr_pkg::CFG_COEF_C: coef_c_reg <= cfg_data[CW-1:0];
                bdr_pkg::CFG_COEF_D: coef_d_reg <= cfg_data[CW-1:0];
                bdr_pkg::CFG_IMG_W:  width_reg  <= cfg_data[DW-1:0];
                bdr_pkg::CFG_IMG_H:  height_reg <= cfg_data[DW-1:0];
                default:             ;
            endcase
        end
    end

    // normalizing radius floor(min(w,h)/2) and its doubled divisor
    logic [DW-2:0] rad_w;
    logic [DW-1:0] dv_w;
    assign rad_w = (width_reg < height_reg) ? width_reg[DW-1:1] : height_reg[DW-1:1];
    assign dv_w  = {rad_w, 1'b0};

    // ------------------------------------------------------------------
    // valid bits and the pixel coordinate travel along every stage
    // ------------------------------------------------------------------
    logic          v_reg [NST];
    logic [XW-1:0] x_reg [NST];
    logic [XW-1:0] y_reg [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= start && !busy;
            for (int k = 1; k < NST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // configuration write waits until no transaction is in flight
    logic pipe_busy_w;

    always_comb
    begin
        pipe_busy_w = 1'b0;
        for (int k = 0; k < NST; k++)
        begin
            pipe_busy_w = pipe_busy_w | v_reg[k];
        end
    end

    assign cfg_ready = !pipe_busy_w;

    always_ff @(posedge clk)
    begin
        x_reg[0] <= dst_x;
        y_reg[0] <= dst_y;
        for (int k = 1; k < NST; k++)
        begin
            x_reg[k] <= x_reg[k-1];
            y_reg[k] <= y_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // squared destination radius (doubled offsets)
    // ------------------------------------------------------------------
    logic signed [OFW-1:0]   dx2_w, dy2_w;
    logic signed [2*OFW-1:0] sqx_full, sqy_full;
    logic [2*MW-1:0]         sqx_reg, sqy_reg;
    logic [SW-1:0]           s_reg;

    assign dx2_w    = center_off(x_reg[ST_SQ-1], width_reg);
    assign dy2_w    = center_off(y_reg[ST_SQ-1], height_reg);
    assign sqx_full = dx2_w * dx2_w;
    assign sqy_full = dy2_w * dy2_w;

    always_ff @(posedge clk)
    begin
        sqx_reg <= sqx_full[2*MW-1:0];
        sqy_reg <= sqy_full[2*MW-1:0];
        s_reg   <= SW'(sqx_reg) + SW'(sqy_reg);
    end

    // ------------------------------------------------------------------
    // square root of s << 24, one root bit per stage
    // ------------------------------------------------------------------
    logic [RMW-1:0] rt_rem_in [RTW];
    logic [RMW-1:0] rt_rem_next [RTW];
    logic [RMW-1:0] rt_rem_reg [RTW];
    logic [RTW-1:0] rt_root_in [RTW];
    logic [RTW-1:0] rt_root_next [RTW];
    logic [RTW-1:0] rt_root_reg [RTW];
    logic [SW-1:0]  rt_s_in [RTW];
    logic [SW-1:0]  rt_s_reg [RTW];

    for (genvar j = 0; j < RTW; j++)
    begin : g_rt
        localparam int PI = RTW - 1 - j;
        logic [NW-1:0]    n_w;
        logic [RMW+1:0]   rs_w;
        logic [RMW+1:0]   tr_w;

        if (j == 0)
        begin : g_first
            assign rt_rem_in[j]  = '0;
            assign rt_root_in[j] = '0;
            assign rt_s_in[j]    = s_reg;
        end
        else
        begin : g_next
            assign rt_rem_in[j]  = rt_rem_reg[j-1];
            assign rt_root_in[j] = rt_root_reg[j-1];
            assign rt_s_in[j]    = rt_s_reg[j-1];
        end

        assign n_w  = NW'(rt_s_in[j]) << bdr_pkg::Q24_SH;
        assign rs_w = {rt_rem_in[j], n_w[2*PI+1 -: 2]};
        assign tr_w = (RMW+2)'({rt_root_in[j], 2'b01});

        always_comb
        begin
            if (rs_w >= tr_w)
            begin
                rt_rem_next[j]  = RMW'(rs_w - tr_w);
                rt_root_next[j] = {rt_root_in[j][RTW-2:0], 1'b1};
            end
            else
            begin
                rt_rem_next[j]  = RMW'(rs_w);
                rt_root_next[j] = {rt_root_in[j][RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            rt_rem_reg[j]  <= rt_rem_next[j];
            rt_root_reg[j] <= rt_root_next[j];
            rt_s_reg[j]    <= rt_s_in[j];
        end
    end

    // ------------------------------------------------------------------
    // root / (2R), one quotient bit per stage
    // ------------------------------------------------------------------
    logic [DW-1:0]  d1_rem_in [RTW];
    logic [DW-1:0]  d1_rem_next [RTW];
    logic [DW-1:0]  d1_rem_reg [RTW];
    logic [RTW-1:0] d1_q_in [RTW];
    logic [RTW-1:0] d1_q_next [RTW];
    logic [RTW-1:0] d1_q_reg [RTW];
    logic [RTW-1:0] d1_n_in [RTW];
    logic [RTW-1:0] d1_n_reg [RTW];

    for (genvar j = 0; j < RTW; j++)
    begin : g_d1
        logic [DW:0] rs_w;

        if (j == 0)
        begin : g_first
            assign d1_rem_in[j] = '0;
            assign d1_q_in[j]   = '0;
            assign d1_n_in[j]   = rt_root_reg[RTW-1];
        end
        else
        begin : g_next
            assign d1_rem_in[j] = d1_rem_reg[j-1];
            assign d1_q_in[j]   = d1_q_reg[j-1];
            assign d1_n_in[j]   = d1_n_reg[j-1];
        end

        assign rs_w = {d1_rem_in[j], d1_n_in[j][RTW-1-j]};

        always_comb
        begin
            if (rs_w >= (DW+1)'(dv_w))
            begin
                d1_rem_next[j] = DW'(rs_w - (DW+1)'(dv_w));
                d1_q_next[j]   = {d1_q_in[j][RTW-2:0], 1'b1};
            end
            else
            begin
                d1_rem_next[j] = DW'(rs_w);
                d1_q_next[j]   = {d1_q_in[j][RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            d1_rem_reg[j] <= d1_rem_next[j];
            d1_q_reg[j]   <= d1_q_next[j];
            d1_n_reg[j]   <= d1_n_in[j];
        end
    end

    // ------------------------------------------------------------------
    // normalized radius t (Q.12), its powers and the lens polynomial
    // ------------------------------------------------------------------
    logic [TW-1:0]         t_reg, t_b_reg, t_c_reg;
    logic [T2W-1:0]        t2_reg, t2_c_reg;
    logic [T3W-1:0]        t3_reg;
    logic [2*TW-1:0]       tt_w;
    logic [T2W+TW-1:0]     t2t_w;
    logic signed [CW+T3W:0] pa_reg;
    logic signed [CW+T2W:0] pb_reg;
    logic signed [CW+TW:0]  pc_reg;
    logic signed [PW-1:0]   p_reg;

    assign tt_w  = t_reg * t_reg;
    assign t2t_w = t2_reg * t_b_reg;

    always_ff @(posedge clk)
    begin
        t_reg    <= (d1_q_reg[RTW-1] > RTW'(bdr_pkg::T_MAX)) ? bdr_pkg::T_MAX
                                                             : TW'(d1_q_reg[RTW-1]);
        t2_reg   <= tt_w[2*TW-1:bdr_pkg::FRAC];
        t_b_reg  <= t_reg;
        t3_reg   <= t2t_w[T2W+TW-1:bdr_pkg::FRAC];
        t2_c_reg <= t2_reg;
        t_c_reg  <= t_b_reg;
        pa_reg   <= coef_a_reg * $signed({1'b0, t3_reg});
        pb_reg   <= coef_b_reg * $signed({1'b0, t2_c_reg});
        pc_reg   <= coef_c_reg * $signed({1'b0, t_c_reg});
        p_reg    <= PW'(pa_reg) + PW'(pb_reg) + PW'(pc_reg)
                  + (PW'(coef_d_reg) <<< bdr_pkg::FRAC);
    end

    // ------------------------------------------------------------------
    // |P| capped, center pixel forced to unity gain
    // ------------------------------------------------------------------
    logic [PW-1:0]  pabs_w;
    logic           center_w;
    logic [MCW-1:0] m_next, m_reg, m_b_reg, m_c_reg, m_d_reg, m_e_reg;

    assign pabs_w   = p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
    assign center_w = (center_off(x_reg[ST_M-1], width_reg) == '0)
                   && (center_off(y_reg[ST_M-1], height_reg) == '0);

    always_comb
    begin
        if (center_w)
        begin
            m_next = bdr_pkg::M_ONE;
        end
        else if (pabs_w > bdr_pkg::M_CAP)
        begin
            m_next = bdr_pkg::M_CAP;
        end
        else
        begin
            m_next = MCW'(pabs_w);
        end
    end

    // ------------------------------------------------------------------
    // source numerators (w-1)*m + dx2*2^24, sign split
    // ------------------------------------------------------------------
    logic [DW+MCW-1:0]      prodx_reg, prody_reg;
    logic [DW+MCW-1:0]      prodx_w, prody_w;
    logic signed [OFW-1:0]  ndx_w, ndy_w;
    logic signed [NUMW-1:0] numx_reg, numy_reg;
    div_lane_t              lx_reg, ly_reg, ovx_reg, ovy_reg;
    logic [NUMW-1:0]        ovlim_w;

    assign prodx_w = (DW+MCW)'(width_reg - DW'(1)) * (DW+MCW)'(m_reg);
    assign prody_w = (DW+MCW)'(height_reg - DW'(1)) * (DW+MCW)'(m_reg);
    assign ndx_w   = center_off(x_reg[ST_NUM-1], width_reg);
    assign ndy_w   = center_off(y_reg[ST_NUM-1], height_reg);
    assign ovlim_w = NUMW'({m_d_reg, 1'b0}) << QW;

    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        prodx_reg <= prodx_w;
        prody_reg <= prody_w;
        m_b_reg   <= m_reg;
        numx_reg  <= $signed({2'b00, prodx_reg})
                   + ({{(NUMW-OFW){ndx_w[OFW-1]}}, ndx_w} <<< bdr_pkg::Q24_SH);
        numy_reg  <= $signed({2'b00, prody_reg})
                   + ({{(NUMW-OFW){ndy_w[OFW-1]}}, ndy_w} <<< bdr_pkg::Q24_SH);
        m_c_reg   <= m_b_reg;

        lx_reg  <= '{rem: (numx_reg[NUMW-1] ? NUMW'(-numx_reg) : NUMW'(numx_reg)),
                     q: '0, neg: numx_reg[NUMW-1], ov: 1'b0};
        ly_reg  <= '{rem: (numy_reg[NUMW-1] ? NUMW'(-numy_reg) : NUMW'(numy_reg)),
                     q: '0, neg: numy_reg[NUMW-1], ov: 1'b0};
        m_d_reg <= m_c_reg;

        // quotient too large for the image
        ovx_reg <= '{rem: lx_reg.rem, q: lx_reg.q, neg: lx_reg.neg,
                     ov: (lx_reg.rem >= ovlim_w)};
        ovy_reg <= '{rem: ly_reg.rem, q: ly_reg.q, neg: ly_reg.neg,
                     ov: (ly_reg.rem >= ovlim_w)};
        m_e_reg <= m_d_reg;
    end

    // ------------------------------------------------------------------
    // |numerator| / 2m, one quotient bit per stage, both axes in parallel
    // ------------------------------------------------------------------
    div_lane_t      d2x_in [QW];
    div_lane_t      d2x_reg [QW];
    div_lane_t      d2y_in [QW];
    div_lane_t      d2y_reg [QW];
    logic [MCW-1:0] d2_m_in [QW];
    logic [MCW-1:0] d2_m_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_d2
        if (j == 0)
        begin : g_first
            assign d2x_in[j]  = ovx_reg;
            assign d2y_in[j]  = ovy_reg;
            assign d2_m_in[j] = m_e_reg;
        end
        else
        begin : g_next
            assign d2x_in[j]  = d2x_reg[j-1];
            assign d2y_in[j]  = d2y_reg[j-1];
            assign d2_m_in[j] = d2_m_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            d2x_reg[j]  <= div_step(d2x_in[j], d2_m_in[j], QW - 1 - j);
            d2y_reg[j]  <= div_step(d2y_in[j], d2_m_in[j], QW - 1 - j);
            d2_m_reg[j] <= d2_m_in[j];
        end
    end

    // ------------------------------------------------------------------
    // bounds check and result register
    // ------------------------------------------------------------------
    div_lane_t     fx_w, fy_w;
    logic          okx_w, oky_w;
    logic          done_reg, in_bounds_reg, in_bounds_next;
    logic [XW-1:0] src_x_reg, src_y_reg, src_x_next, src_y_next;

    assign fx_w  = d2x_reg[QW-1];
    assign fy_w  = d2y_reg[QW-1];
    // negative quotient is outside unless it truncates to zero
    assign okx_w = !fx_w.ov && !(fx_w.neg && (fx_w.q != '0)) && (fx_w.q < width_reg);
    assign oky_w = !fy_w.ov && !(fy_w.neg && (fy_w.q != '0)) && (fy_w.q < height_reg);

    always_comb
    begin
        if (rad_w == '0)
        begin
            // degenerate image: identity
            src_x_next     = x_reg[NST-1];
            src_y_next     = y_reg[NST-1];
            in_bounds_next = (DW'(x_reg[NST-1]) < width_reg)
                          && (DW'(y_reg[NST-1]) < height_reg);
        end
        else if ((d2_m_reg[QW-1] == '0) || !(okx_w && oky_w))
        begin
            src_x_next     = '0;
            src_y_next     = '0;
            in_bounds_next = 1'b0;
        end
        else
        begin
            src_x_next     = XW'(fx_w.q);
            src_y_next     = XW'(fy_w.q);
            in_bounds_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            in_bounds_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= v_reg[NST-1];
            in_bounds_reg <= v_reg[NST-1] && in_bounds_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_x_reg <= src_x_next;
        src_y_reg <= src_y_next;
    end

    assign done      = done_reg;
    assign src_x     = src_x_reg;
    assign src_y     = src_y_reg;
    assign in_bounds = in_bounds_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // every accepted transaction produces exactly one strobe at fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction did not produce a result");

    a_done_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without an accepted transaction");

    // an in-bounds source always lies inside the configured width and height
    a_in_bounds_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_bounds) |-> ((DW'(src_x) < width_reg) && (DW'(src_y) < height_reg)))
        else $error("in-bounds source outside the image");

    a_in_bounds_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        in_bounds |-> done)
        else $error("in_bounds raised without a result strobe");

endmodule
